// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the frame store writer RTL.
// Depends on a clock named clk and an active-high reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds at the following clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mfbw_pkg.sv =====
// Types and constants of the monochrome frame store pixel writer.
// No dependencies; used by every module of the block.
package mfbw_pkg;

  localparam int X_W     = 9;
  localparam int Y_W     = 9;
  localparam int COLOR_W = 16;
  localparam int INDEX_W = 14;
  localparam int BYTE_W  = 8;

  localparam logic [COLOR_W-1:0] WHITE_THRESHOLD = 16'h7FFF;
  localparam logic [BYTE_W-1:0]  BLANK_BYTE      = 8'hFF;
  localparam logic [BYTE_W-1:0]  TOP_BIT_MASK    = 8'h80;

  typedef enum logic [0:0] {
    CMD_WRITE_PIXEL = 1'b0,
    CMD_READ_BYTE   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [X_W-1:0]     pixel_x;
    logic [Y_W-1:0]     pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic [INDEX_W-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  byte_value;
    logic [INDEX_W-1:0] byte_index_echo;
  } rsp_t;

  typedef struct packed {
    logic               is_read;
    logic               wr_ok;
    logic               white;
    logic [BYTE_W-1:0]  bit_mask;
    logic               read_ok;
    logic [INDEX_W-1:0] index_echo;
  } op_t;

endpackage

// ===== hdl/mfbw_decode.sv =====
// Decodes one request into a frame store address, a bit mask and control flags.
// Depends on mfbw_pkg.
module mfbw_decode #(
  parameter int PANEL_WIDTH  = 400,
  parameter int PANEL_HEIGHT = 300,
  parameter int FRAME_DEPTH  = 15000,
  parameter int ADDR_W       = 14
) (
  input  mfbw_pkg::req_t      req,
  output mfbw_pkg::op_t       op,
  output logic [ADDR_W-1:0]   addr
);

  localparam int ROWS      = PANEL_HEIGHT / 4;
  localparam int IDX_BOUND = (PANEL_WIDTH / 2) * ROWS + ROWS + 1;
  localparam int IDX_W     = (IDX_BOUND > 2) ? $clog2(IDX_BOUND) : 1;

  logic [9:0]       flip_y;
  logic [IDX_W-1:0] pix_index;
  logic             in_panel;
  logic             index_ok;
  logic             is_read;

  assign flip_y    = 10'(PANEL_HEIGHT - 1) - {1'b0, req.pixel_y};
  assign pix_index = IDX_W'(req.pixel_x[8:1]) * IDX_W'(ROWS) + IDX_W'(flip_y[9:2]);
  assign in_panel  = (32'(req.pixel_x) < 32'(PANEL_WIDTH)) &&
                     (32'(req.pixel_y) < 32'(PANEL_HEIGHT));
  assign index_ok  = 32'(pix_index) < 32'(FRAME_DEPTH);
  assign is_read   = (req.command == mfbw_pkg::CMD_READ_BYTE);

  always_comb begin
    op.is_read    = is_read;
    op.wr_ok      = !is_read && in_panel && index_ok;
    op.white      = req.pixel_color >= mfbw_pkg::WHITE_THRESHOLD;
    op.bit_mask   = mfbw_pkg::TOP_BIT_MASK >> {flip_y[1:0], req.pixel_x[0]};
    op.read_ok    = 32'(req.read_index) < 32'(FRAME_DEPTH);
    op.index_echo = req.read_index;
    addr          = is_read ? ADDR_W'(req.read_index) : ADDR_W'(pix_index);
  end

endmodule

// ===== hdl/mfbw_store.sv =====
// Single-port-write, single-port-read byte memory holding the frame store.
// Read data is registered. Depends on mfbw_pkg.
module mfbw_store #(
  parameter int DEPTH  = 15000,
  parameter int ADDR_W = 14
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [mfbw_pkg::BYTE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [mfbw_pkg::BYTE_W-1:0] rd_data
);

  logic [mfbw_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/mono_framebuffer_pixel_writer_unit.sv =====
// Top level of the 1-bit-per-pixel frame store: pixel writes by read-modify-write, byte reads.
// Depends on mfbw_pkg, mfbw_decode, mfbw_store and assert_macros.svh.
//
// Usage: after reset the block sweeps the whole frame store to white, one byte per cycle,
// PANEL_WIDTH*PANEL_HEIGHT/8 bytes (15000 at the default size), with req_ready low.
// It then takes one request per cycle while the pipeline is not stalled. A request is decoded
// into the s1 register, the store is read as it moves on to s2, and in s2 a pixel write merges
// its bit and writes the byte back while a byte read loads the response register. A write to
// the byte that the previous write touched is forwarded from a holding register. The pipeline
// stalls only while a read result waits for rsp_ready with the response register full. Writes
// outside the panel are dropped; reads past the store return zero.
`include "assert_macros.svh"

module mono_framebuffer_pixel_writer_unit #(
  parameter int PANEL_WIDTH  = 400,
  parameter int PANEL_HEIGHT = 300
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mfbw_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mfbw_pkg::rsp_t rsp
);

  localparam int FRAME_DEPTH = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
  localparam int ADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

  mfbw_pkg::op_t               dec_op;
  logic [ADDR_W-1:0]           dec_addr;

  logic                        clearing;
  logic [ADDR_W-1:0]           clear_cnt;

  logic                        s1_valid;
  mfbw_pkg::op_t               s1_op;
  logic [ADDR_W-1:0]           s1_addr;
  logic                        s2_valid;
  mfbw_pkg::op_t               s2_op;
  logic [ADDR_W-1:0]           s2_addr;

  logic                        fwd_valid;
  logic [ADDR_W-1:0]           fwd_addr;
  logic [mfbw_pkg::BYTE_W-1:0] fwd_data;

  logic                        advance;
  logic                        pix_we;
  logic                        rsp_load;
  logic [mfbw_pkg::BYTE_W-1:0] rd_data;
  logic [mfbw_pkg::BYTE_W-1:0] cur_byte;
  logic [mfbw_pkg::BYTE_W-1:0] mod_byte;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [mfbw_pkg::BYTE_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]           mem_raddr;

  mfbw_decode #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .FRAME_DEPTH  (FRAME_DEPTH),
    .ADDR_W       (ADDR_W)
  ) u_decode (
    .req  (req),
    .op   (dec_op),
    .addr (dec_addr)
  );

  mfbw_store #(
    .DEPTH  (FRAME_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (rd_data)
  );

  assign advance   = !(s2_valid && s2_op.is_read && rsp_valid && !rsp_ready);
  assign req_ready = !clearing && advance;
  assign rsp_load  = s2_valid && s2_op.is_read && advance;
  assign pix_we    = s2_valid && s2_op.wr_ok;

  assign cur_byte  = (fwd_valid && (fwd_addr == s2_addr)) ? fwd_data : rd_data;
  assign mod_byte  = s2_op.white ? (cur_byte | s2_op.bit_mask) : (cur_byte & ~s2_op.bit_mask);

  assign mem_we    = clearing || pix_we;
  assign mem_waddr = clearing ? clear_cnt : s2_addr;
  assign mem_wdata = clearing ? mfbw_pkg::BLANK_BYTE : mod_byte;
  assign mem_raddr = advance ? s1_addr : s2_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_cnt <= '0;
    end else if (clearing) begin
      if (clear_cnt == ADDR_W'(FRAME_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clear_cnt <= clear_cnt + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid <= req_valid && req_ready;
        s2_valid <= s1_valid;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (pix_we) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op   <= dec_op;
      s1_addr <= dec_addr;
      s2_op   <= s1_op;
      s2_addr <= s1_addr;
    end
    if (pix_we) begin
      fwd_addr <= s2_addr;
      fwd_data <= mod_byte;
    end
    if (rsp_load) begin
      rsp.byte_value      <= s2_op.read_ok ? cur_byte : '0;
      rsp.byte_index_echo <= s2_op.index_echo;
    end
  end

  `ASSERT_ALWAYS(a_no_pipe_during_clear, !(clearing && (s1_valid || s2_valid)), "pipeline busy during clear")
  `ASSERT_NEXT(a_read_loads_rsp, rsp_load, rsp_valid, "read result not loaded")
  `ASSERT_NEXT(a_write_sets_fwd, pix_we, fwd_valid && (fwd_addr == $past(s2_addr)), "forward register missed a write")
  `ASSERT_NEXT(a_clear_ends, clearing && (clear_cnt == ADDR_W'(FRAME_DEPTH - 1)), !clearing, "clear pass overran")

endmodule

// ===== tb/tb_mono_framebuffer_pixel_writer_unit.sv =====
// Self-checking testbench for the 1-bit-per-pixel frame store: pixel writes and byte reads.
// Depends on mfbw_pkg and mono_framebuffer_pixel_writer_unit; a local frame model predicts reads.
module tb_mono_framebuffer_pixel_writer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mfbw_pkg::*;

  localparam int PANEL_WIDTH  = 400;
  localparam int PANEL_HEIGHT = 300;
  localparam int FRAME_DEPTH  = PANEL_WIDTH * PANEL_HEIGHT / 8;
  localparam int COLUMN_BYTES = PANEL_HEIGHT / 4;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int CYCLE_LIMIT  = 250000;

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t typed_rsp;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  logic [BYTE_W-1:0] frame_model [FRAME_DEPTH];
  rsp_t              pending_bytes [$];
  directed_row_t     directed_rows [$];
  int                byte_mismatches = 0;
  int                results_checked = 0;
  int                burst_left = 0;
  int                cycle_count = 0;

  mono_framebuffer_pixel_writer_unit #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void update_frame_model(input req_t item);
    int unsigned fy;
    int unsigned byte_idx;
    int unsigned bit_pos;
    rsp_t        read_back;
    if (item.command == CMD_WRITE_PIXEL) begin
      if (item.pixel_x < PANEL_WIDTH && item.pixel_y < PANEL_HEIGHT) begin
        fy = PANEL_HEIGHT - 1 - item.pixel_y;
        byte_idx = (item.pixel_x >> 1) * COLUMN_BYTES + (fy >> 2);
        if (byte_idx < FRAME_DEPTH) begin
          bit_pos = 7 - (((fy & 3) << 1) | (item.pixel_x & 1));
          frame_model[byte_idx[INDEX_W-1:0]][bit_pos[2:0]] =
            (item.pixel_color >= WHITE_THRESHOLD);
        end
      end
    end else begin
      read_back.byte_value = (item.read_index < FRAME_DEPTH) ? frame_model[item.read_index] : '0;
      read_back.byte_index_echo = item.read_index;
      pending_bytes.push_back(read_back);
    end
  endfunction

  function automatic directed_row_t make_row(input cmd_t cmd, input int unsigned x,
                                             input int unsigned y, input int unsigned color,
                                             input int unsigned idx, input bit typed,
                                             input int unsigned byte_val);
    directed_row_t row;
    row.item.command     = cmd;
    row.item.pixel_x     = x[X_W-1:0];
    row.item.pixel_y     = y[Y_W-1:0];
    row.item.pixel_color = color[COLOR_W-1:0];
    row.item.read_index  = idx[INDEX_W-1:0];
    row.typed            = typed;
    row.typed_rsp.byte_value      = byte_val[BYTE_W-1:0];
    row.typed_rsp.byte_index_echo = idx[INDEX_W-1:0];
    return row;
  endfunction

  // Most traffic lands on small windows at all four corners of the panel, so that
  // reads see bytes that earlier writes have changed.
  function automatic req_t random_request();
    req_t        item;
    int unsigned roll;
    bit          far_x;
    bit          far_y;
    item.command     = CMD_WRITE_PIXEL;
    item.pixel_x     = X_W'($urandom_range(0, 511));
    item.pixel_y     = Y_W'($urandom_range(0, 511));
    item.pixel_color = COLOR_W'($urandom_range(0, 65535));
    item.read_index  = INDEX_W'($urandom_range(0, 16383));
    roll  = $urandom_range(0, 99);
    far_x = 1'($urandom_range(0, 1));
    far_y = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 1) == 0) begin
      item.pixel_color = COLOR_W'($urandom_range(16'h7FF8, 16'h8007));
    end
    if (roll < 40) begin
      item.pixel_x = X_W'(far_x ? $urandom_range(PANEL_WIDTH - 8, PANEL_WIDTH - 1)
                                : $urandom_range(0, 7));
      item.pixel_y = Y_W'(far_y ? $urandom_range(PANEL_HEIGHT - 16, PANEL_HEIGHT - 1)
                                : $urandom_range(0, 15));
    end else if (roll < 70) begin
      item.command    = CMD_READ_BYTE;
      item.read_index = INDEX_W'((far_x ? $urandom_range(PANEL_WIDTH / 2 - 4, PANEL_WIDTH / 2 - 1)
                                        : $urandom_range(0, 3)) * COLUMN_BYTES
                               + (far_y ? $urandom_range(0, 3)
                                        : $urandom_range(COLUMN_BYTES - 4, COLUMN_BYTES - 1)));
    end else if (roll < 80) begin
      item.pixel_x = X_W'($urandom_range(0, PANEL_WIDTH - 1));
      item.pixel_y = Y_W'($urandom_range(0, PANEL_HEIGHT - 1));
    end else if (roll < 90) begin
      item.command = CMD_READ_BYTE;
    end else if (roll < 95) begin
      if (far_x) begin
        item.pixel_x = X_W'($urandom_range(PANEL_WIDTH, 511));
      end else begin
        item.pixel_y = Y_W'($urandom_range(PANEL_HEIGHT, 511));
      end
    end else begin
      item.command    = CMD_READ_BYTE;
      item.read_index = INDEX_W'($urandom_range(FRAME_DEPTH, 16383));
    end
    return item;
  endfunction

  task automatic note_failure(input string what);
    byte_mismatches++;
    if (byte_mismatches <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic offer_request(input req_t item, input bit typed, input rsp_t typed_rsp);
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    if (typed) begin
      pending_bytes.push_back(typed_rsp);
    end else begin
      update_frame_model(item);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      results_checked++;
      if (pending_bytes.size() == 0) begin
        note_failure($sformatf("unexpected transfer: byte %h index %0d",
                               rsp.byte_value, rsp.byte_index_echo));
      end else begin
        want = pending_bytes.pop_front();
        if (rsp.byte_value !== want.byte_value ||
            rsp.byte_index_echo !== want.byte_index_echo) begin
          note_failure($sformatf("byte %h index %0d, expected byte %h index %0d",
                                 rsp.byte_value, rsp.byte_index_echo,
                                 want.byte_value, want.byte_index_echo));
        end
      end
    end
  end

  // Receiver: moves between three stall patterns, each picked at random, and holds off once for
  // a long stretch so that the pipeline fills and blocks new requests.
  initial begin
    int  mode;
    int  phase_left;
    bit  hold_done;
    rsp_ready <= 1'b0;
    mode       = 0;
    phase_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && results_checked >= 40) begin
        hold_done = 1'b1;
        rsp_ready <= 1'b0;
        for (int n = 1; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        if (phase_left == 0) begin
          phase_left = 50;
          mode = $urandom_range(0, 2);
        end
        phase_left--;
        case (mode)
          0: begin
            rsp_ready <= 1'b1;
          end
          1: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    foreach (frame_model[i]) frame_model[i] = BLANK_BYTE;

    // Reads straight after the clearing pass, and reads past the store.
    directed_rows.push_back(make_row(CMD_READ_BYTE, 511, 511, 16'hFFFF, 0, 1, 8'hFF));
    directed_rows.push_back(make_row(CMD_READ_BYTE, 0, 0, 0, FRAME_DEPTH - 1, 1, 8'hFF));
    directed_rows.push_back(make_row(CMD_READ_BYTE, 0, 0, 0, FRAME_DEPTH, 1, 8'h00));
    directed_rows.push_back(make_row(CMD_READ_BYTE, 0, 0, 0, 16383, 1, 8'h00));
    // Corner pixels, colors on both sides of the white threshold.
    directed_rows.push_back(make_row(CMD_WRITE_PIXEL, 0, 0, 16'h0000, 16383, 0, 0));
    directed_rows.push_back(make_row(CMD_READ_BYTE, 0, 0, 0, 74, 0, 0));
    directed_rows.push_back(make_row(CMD_WRITE_PIXEL, 399, 299, 16'h7FFE, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_READ_BYTE, 0, 0, 0, 14925, 0, 0));
    directed_rows.push_back(make_row(CMD_WRITE_PIXEL, 399, 299, 16'h7FFF, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_READ_BYTE, 0, 0, 0, 14925, 0, 0));
    // Writes outside the panel leave the store alone.
    directed_rows.push_back(make_row(CMD_WRITE_PIXEL, 400, 0, 16'h0000, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_WRITE_PIXEL, 511, 511, 16'h0000, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_WRITE_PIXEL, 0, 300, 16'h0000, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_READ_BYTE, 0, 0, 0, 0, 0, 0));
    // Successive writes to one byte, then a read that follows a write to the same byte.
    directed_rows.push_back(make_row(CMD_WRITE_PIXEL, 1, 0, 16'h0000, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_WRITE_PIXEL, 0, 1, 16'h0000, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_WRITE_PIXEL, 1, 1, 16'hFFFF, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_READ_BYTE, 0, 0, 0, 74, 0, 0));
    directed_rows.push_back(make_row(CMD_WRITE_PIXEL, 0, 0, 16'hFFFF, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_READ_BYTE, 511, 511, 16'hFFFF, 74, 0, 0));
    directed_rows.push_back(make_row(CMD_WRITE_PIXEL, 256, 256, 16'h8000, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_READ_BYTE, 0, 0, 0, 128 * COLUMN_BYTES + 10, 0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      pace_sender();
      offer_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].typed_rsp);
    end
    repeat (RANDOM_ITEMS) begin
      pace_sender();
      offer_request(random_request(), 1'b0, '0);
    end
    req_valid <= 1'b0;

    for (int n = 0; n < DRAIN_LIMIT && pending_bytes.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      note_failure($sformatf("%0d read results never arrived", pending_bytes.size()));
    end

    if (byte_mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
